>>> hw/rtl/swmdl_pkg.sv
// Shared types, command codes and constants of the signed-log position dequantiser.
package swmdl_pkg;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_SCAN   = 2'd1;
	localparam logic [1:0] CMD_DECODE = 2'd2;

	// e in Q20
	localparam logic [63:0] E_Q20 = 64'd2850325;

	localparam logic signed [35:0] OUT_MAX = 36'sh7FFFFFFFF;
	localparam logic signed [35:0] OUT_MIN = 36'sh800000000;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] low_x;
		logic [7:0] low_y;
		logic [7:0] low_z;
		logic [7:0] high_x;
		logic [7:0] high_y;
		logic [7:0] high_z;
	} in_t;

	typedef struct packed {
		logic signed [35:0] pos_x;
		logic signed [35:0] pos_y;
		logic signed [35:0] pos_z;
		logic               saturated;
	} out_t;

	typedef struct packed {
		logic signed [35:0] pos;
		logic               sat;
	} lane_res_t;

	// e^n in Q20, each step rounded half up
	function automatic logic [41:0] en_of(input int n);
		logic [63:0] en;
		en = 64'd1 << 20;
		for (int i = 0; i < n; i++) begin
			en = (en * E_Q20 + (64'd1 << 19)) >> 20;
		end
		return en[41:0];
	endfunction

endpackage

>>> hw/rtl/swmdl_lane.sv
// One channel lane: linear map by division, then sign(s)*(exp(|s|)-1) with saturation.
module swmdl_lane (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   ack,
	input  logic [15:0]            word,
	input  logic [15:0]            min,
	input  logic [15:0]            span,
	input  logic signed [23:0]     low,
	input  logic signed [24:0]     d,
	output logic                   done,
	output swmdl_pkg::lane_res_t   res
);

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_MUL  = 10'b0000000010,
		S_DIV  = 10'b0000000100,
		S_SGN  = 10'b0000001000,
		S_TM   = 10'b0000010000,
		S_TD   = 10'b0000100000,
		S_PRD  = 10'b0001000000,
		S_PRH  = 10'b0010000000,
		S_FIN  = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	state_t state_q;
	logic signed [16:0] num_q;
	logic signed [24:0] d_q;
	logic [15:0]        span_q;
	logic signed [23:0] low_q;
	logic               neg_q;
	logic [16:0]        rem_q;
	logic [47:0]        quo_q;
	logic [15:0]        dv_q;
	logic [2:0]         cnt_q;
	logic [3:0]         n_q;
	logic [15:0]        f_q;
	logic [32:0]        term_q;
	logic [33:0]        sum_q;
	logic [3:0]         k_q;
	logic               sgn_q;
	logic [63:0]        prod_q;
	swmdl_pkg::lane_res_t res_q;

	logic [41:0] en_tab [16];

	// e^n table, constant per entry
	for (genvar i = 0; i < 16; i++) begin : g_en
		assign en_tab[i] = swmdl_pkg::en_of(i);
	end

	// Eight restoring division steps per cycle
	logic [16:0] rem_n;
	logic [47:0] quo_n;
	always_comb begin
		logic [16:0] r;
		logic [47:0] qv;
		r  = rem_q;
		qv = quo_q;
		for (int b = 0; b < 8; b++) begin
			r  = {r[15:0], qv[47]};
			qv = {qv[46:0], 1'b0};
			if (r >= {1'b0, dv_q}) begin
				r     = r - {1'b0, dv_q};
				qv[0] = 1'b1;
			end
		end
		rem_n = r;
		quo_n = qv;
	end

	// Product and magnitude of the numerator
	logic signed [41:0] p_w;
	logic [41:0]        pabs_w;
	assign p_w    = num_q * d_q;
	assign pabs_w = p_w[41] ? 42'(-p_w) : p_w;

	// Floored quotient and signed-log value
	logic signed [42:0] q_w;
	logic signed [42:0] s_w;
	logic [42:0]        a_w;
	always_comb begin
		q_w = neg_q ? -($signed(quo_q[42:0]) + 43'sd1 * 43'(rem_q != 17'd0)) :
			$signed(quo_q[42:0]);
		s_w = 43'(low_q) + q_w;
		a_w = s_w[42] ? 43'(-s_w) : 43'(s_w);
	end

	logic [48:0] tf_w;
	assign tf_w = term_q * f_q;

	logic [21:0] ef20_w;
	assign ef20_w = 22'((sum_q + 34'd2048) >> 12);

	// Final product in two halves of e^n, low half first
	logic [41:0] en_w;
	logic [20:0] en_part_w;
	logic [42:0] pp_w;
	assign en_w      = en_tab[n_q];
	assign en_part_w = (state_q == S_PRH) ? en_w[41:21] : en_w[20:0];
	assign pp_w      = en_part_w * ef20_w;

	logic [36:0] mag_w;
	assign mag_w = 37'((prod_q + (64'd1 << 27)) >> 28) - 37'd4096;

	// Sequence one channel through map, series and final product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						num_q   <= $signed({1'b0, word}) - $signed({1'b0, min});
						d_q     <= d;
						span_q  <= span;
						low_q   <= low;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					neg_q   <= p_w[41];
					quo_q   <= 48'(pabs_w);
					rem_q   <= '0;
					dv_q    <= span_q;
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= rem_n;
					quo_q <= quo_n;
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5) state_q <= S_SGN;
				end
				S_SGN: begin
					sgn_q  <= s_w[42];
					n_q    <= a_w[19:16];
					f_q    <= a_w[15:0];
					term_q <= 33'd1 << 32;
					sum_q  <= 34'd1 << 32;
					k_q    <= 4'd1;
					if (a_w >= 43'd1048576) begin
						res_q.pos <= s_w[42] ? swmdl_pkg::OUT_MIN : swmdl_pkg::OUT_MAX;
						res_q.sat <= 1'b1;
						state_q   <= S_DONE;
					end else begin
						state_q <= S_TM;
					end
				end
				S_TM: begin
					quo_q   <= 48'(tf_w >> 16);
					rem_q   <= '0;
					dv_q    <= 16'(k_q);
					cnt_q   <= '0;
					state_q <= S_TD;
				end
				S_TD: begin
					rem_q <= rem_n;
					quo_q <= quo_n;
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd5) begin
						term_q <= quo_n[32:0];
						sum_q  <= sum_q + 34'(quo_n[32:0]);
						k_q    <= k_q + 4'd1;
						state_q <= (k_q == 4'd12) ? S_PRD : S_TM;
					end
				end
				S_PRD: begin
					prod_q  <= 64'(pp_w);
					state_q <= S_PRH;
				end
				S_PRH: begin
					prod_q  <= prod_q + {pp_w, 21'd0};
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!sgn_q) begin
						res_q.sat <= mag_w > 37'h7FFFFFFFF;
						res_q.pos <= (mag_w > 37'h7FFFFFFFF) ? swmdl_pkg::OUT_MAX :
							$signed(mag_w[35:0]);
					end else begin
						res_q.sat <= mag_w > 37'h800000000;
						res_q.pos <= (mag_w > 37'h800000000) ? swmdl_pkg::OUT_MIN :
							-$signed(mag_w[35:0]);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (ack) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done = (state_q == S_DONE);
	assign res  = res_q;

endmodule

>>> hw/rtl/split_word_minmax_dequant_signed_log_unit.sv
// Top level: min/max window, lane launch and merge of lane results into one transfer.
// A decode item passes through each lane's 48-bit division by the span, the
// twelve-term exponential series with a division by the term index per term, and the
// final product in two halves; lanes run side by side. Clear and scan items update
// the window and give no result. Input is stalled while a decode is in the lanes; the
// output register lets the next item in once loaded.
module split_word_minmax_dequant_signed_log_unit #(
	parameter int LANES = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  swmdl_pkg::in_t     in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output swmdl_pkg::out_t    out_data,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data
);

	localparam int NCH = (LANES < 3) ? LANES : 3;

	logic signed [23:0] low_q, high_q;
	logic [15:0]        min_q, max_q;
	logic               busy_q, out_valid_q;
	swmdl_pkg::out_t    out_q;

	logic [15:0] w [3];
	assign w[0] = {in_data.high_x, in_data.low_x};
	assign w[1] = {in_data.high_y, in_data.low_y};
	assign w[2] = {in_data.high_z, in_data.low_z};

	logic accept, start, move;
	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign start    = accept && (in_data.command == swmdl_pkg::CMD_DECODE);

	// Span and range width for the lanes
	logic [15:0]        span_w;
	logic signed [24:0] d_w;
	assign span_w = (max_q > min_q) ? (max_q - min_q) : 16'd1;
	assign d_w    = 25'(high_q) - 25'(low_q);

	// Widen the window with the active channels
	logic [15:0] min_n, max_n;
	always_comb begin
		min_n = min_q;
		max_n = max_q;
		for (int c = 0; c < 3; c++) begin
			if (c < NCH) begin
				if (w[c] < min_n) min_n = w[c];
				if (w[c] > max_n) max_n = w[c];
			end
		end
	end

	logic                 done_w [3];
	swmdl_pkg::lane_res_t lres [3];

	for (genvar c = 0; c < 3; c++) begin : g_lane
		if (c < NCH) begin : g_on
			swmdl_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.start  (start),
				.ack    (move),
				.word   (w[c]),
				.min    (min_q),
				.span   (span_w),
				.low    (low_q),
				.d      (d_w),
				.done   (done_w[c]),
				.res    (lres[c])
			);
		end else begin : g_off
			assign done_w[c] = 1'b1;
			assign lres[c]   = '0;
		end
	end

	assign move = busy_q && done_w[0] && done_w[1] && done_w[2] &&
		(!out_valid_q || !out_stall);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= 24'sd0;
			high_q <= 24'sd65536;
		end else if (cfg_we) begin
			if (cfg_index) high_q <= cfg_data;
			else           low_q  <= cfg_data;
		end
	end

	// Window, busy flag and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= 16'hFFFF;
			max_q       <= 16'h0000;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				case (in_data.command)
					swmdl_pkg::CMD_CLEAR: begin
						min_q <= 16'hFFFF;
						max_q <= 16'h0000;
					end
					swmdl_pkg::CMD_SCAN: begin
						min_q <= min_n;
						max_q <= max_n;
					end
					default: ;
				endcase
			end
			if (start) busy_q <= 1'b1;
			else if (move) busy_q <= 1'b0;
			if (move) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Merge lane results
	always_ff @(posedge clk) begin
		if (move) begin
			out_q.pos_x     <= lres[0].pos;
			out_q.pos_y     <= lres[1].pos;
			out_q.pos_z     <= lres[2].pos;
			out_q.saturated <= lres[0].sat | lres[1].sat | lres[2].sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
